// ----- hdl/tbdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// tbdlp_pkg
// shared types and constants for the three-button debounce block
// ----------------------------------------------------------------------------
`default_nettype none

package tbdlp_pkg;

  localparam int HOLD_BITS_DEF = 16;
  localparam int NUM_LANES     = 3;
  localparam int DEB_W         = 4;
  localparam int LONG_W        = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 4'd3;
  localparam logic [LONG_W-1:0] LONG_PRESS_RST = 16'd50;

  // lane order
  localparam int LANE_RECORD = 0;
  localparam int LANE_EFFECT = 1;
  localparam int LANE_VOLUME = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 1'b0,
    CFG_LONG_PRESS = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_RECORD        = 3'd0,
    KIND_STOP          = 3'd1,
    KIND_NEXT_EFFECT   = 3'd2,
    KIND_TOGGLE_MUTE   = 3'd3,
    KIND_ADJUST_VOLUME = 3'd4
  } kind_t;

  typedef struct packed {
    logic press;
    logic release_evt;
    logic is_long;
  } lane_stat_t;

endpackage

`default_nettype wire

// ----- hdl/tbdlp_lane.sv -----
// ----------------------------------------------------------------------------
// tbdlp_lane
// counter debounce and saturating hold counter for one button
// ----------------------------------------------------------------------------
`default_nettype none

module tbdlp_lane #(
  parameter int HOLD_BITS = tbdlp_pkg::HOLD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step_en,
  input  wire logic                          sample,
  input  wire logic [tbdlp_pkg::DEB_W-1:0]   debounce_count,
  input  wire logic [tbdlp_pkg::LONG_W-1:0]  long_press_count,
  output tbdlp_pkg::lane_stat_t              stat
);
  import tbdlp_pkg::*;

  localparam int CMP_W = (HOLD_BITS > LONG_W) ? HOLD_BITS : LONG_W;

  logic                 last_r,   last_nxt;
  logic [DEB_W-1:0]     agree_r,  agree_nxt;
  logic                 stable_r, stable_nxt;
  logic [HOLD_BITS-1:0] hold_r,   hold_nxt;
  logic                 change;

  always_comb begin
    last_nxt   = sample;
    stable_nxt = stable_r;
    hold_nxt   = hold_r;
    if (sample == last_r) begin
      agree_nxt = (agree_r < debounce_count) ? agree_r + DEB_W'(1) : agree_r;
    end else begin
      agree_nxt = DEB_W'(1);
    end
    change = !((agree_nxt < debounce_count) || (stable_r == sample));
    if (!change) begin
      if (stable_r && !(&hold_r)) begin
        hold_nxt = hold_r + HOLD_BITS'(1);
      end
    end else begin
      stable_nxt = sample;
      if (sample) begin
        hold_nxt = '0;
      end
    end
  end

  // release compares the hold count from before this tick
  assign stat.press       = change && sample;
  assign stat.release_evt = change && !sample;
  assign stat.is_long     = CMP_W'(hold_r) >= CMP_W'(long_press_count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= 1'b0;
      agree_r  <= '0;
      stable_r <= 1'b0;
      hold_r   <= '0;
    end else if (step_en) begin
      last_r   <= last_nxt;
      agree_r  <= agree_nxt;
      stable_r <= stable_nxt;
      hold_r   <= hold_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tbdlp_merge.sv -----
// ----------------------------------------------------------------------------
// tbdlp_merge
// priority merge of lane events into one registered intent
// ----------------------------------------------------------------------------
`default_nettype none

module tbdlp_merge (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   load,
  input  wire logic                                   read_failed,
  input  wire tbdlp_pkg::lane_stat_t [tbdlp_pkg::NUM_LANES-1:0] stat,
  input  wire logic                                   out_ready,
  output logic                                        out_valid,
  output logic                                        intent_valid,
  output logic [2:0]                                  intent_kind
);
  import tbdlp_pkg::*;

  logic  out_valid_r, out_valid_nxt;
  logic  ivalid_r, ivalid_nxt;
  kind_t kind_r, kind_nxt;

  always_comb begin
    ivalid_nxt = 1'b0;
    kind_nxt   = KIND_RECORD;
    if (!read_failed) begin
      if (stat[LANE_RECORD].press) begin
        ivalid_nxt = 1'b1;
        kind_nxt   = KIND_RECORD;
      end else if (stat[LANE_EFFECT].release_evt) begin
        ivalid_nxt = 1'b1;
        kind_nxt   = stat[LANE_EFFECT].is_long ? KIND_STOP : KIND_NEXT_EFFECT;
      end else if (stat[LANE_VOLUME].release_evt) begin
        ivalid_nxt = 1'b1;
        kind_nxt   = stat[LANE_VOLUME].is_long ? KIND_TOGGLE_MUTE : KIND_ADJUST_VOLUME;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ivalid_r <= ivalid_nxt;
      kind_r   <= kind_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign intent_valid = ivalid_r;
  assign intent_kind  = kind_r;

endmodule

`default_nettype wire

// ----- hdl/three_button_debounce_long_press.sv -----
// ----------------------------------------------------------------------------
// three_button_debounce_long_press
// three parallel button debouncers with long-press detection and intent merge
// the result is valid in the cycle after the input transfer (registered output)
// throughput: one item per cycle; input is taken while a result waits if
//   out_ready is high in the same cycle
// reset: synchronous active-low rst_n clears lane state and output valid,
//   and loads debounce_count 3, long_press_count 50
// ----------------------------------------------------------------------------
`default_nettype none

module three_button_debounce_long_press #(
  parameter int HOLD_BITS = tbdlp_pkg::HOLD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_record_level,
  input  wire logic                              in_effect_level,
  input  wire logic                              in_volume_level,
  input  wire logic                              in_read_failed,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_intent_valid,
  output logic [2:0]                             out_intent_kind,
  input  wire logic                              cfg_we,
  input  wire logic [tbdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tbdlp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tbdlp_pkg::*;

  logic [DEB_W-1:0]  debounce_r;
  logic [LONG_W-1:0] long_press_r;
  logic              in_xfer;
  logic              step_en;
  logic [NUM_LANES-1:0] samples;
  lane_stat_t [NUM_LANES-1:0] stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[DEB_W-1:0];
        CFG_LONG_PRESS: long_press_r <= cfg_wdata[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign step_en  = in_xfer && !in_read_failed;

  assign samples[LANE_RECORD] = in_record_level;
  assign samples[LANE_EFFECT] = in_effect_level;
  assign samples[LANE_VOLUME] = in_volume_level;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    tbdlp_lane #(
      .HOLD_BITS(HOLD_BITS)
    ) u_lane (
      .clk              (clk),
      .rst_n            (rst_n),
      .step_en          (step_en),
      .sample           (samples[g]),
      .debounce_count   (debounce_r),
      .long_press_count (long_press_r),
      .stat             (stat[g])
    );
  end

  tbdlp_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (in_xfer),
    .read_failed  (in_read_failed),
    .stat         (stat),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .intent_valid (out_intent_valid),
    .intent_kind  (out_intent_kind)
  );

endmodule

`default_nettype wire
